// ===== hdl/ppw_pkg.sv =====
// Shared types and constants for the periodic position wrap block.
package ppw_pkg;

   localparam int POS_FRAC    = 16;
   localparam int INV_FRAC    = 30;
   localparam int PROD_FRAC   = POS_FRAC + INV_FRAC;
   localparam int NUM_COEF    = 18;
   localparam int INV_BASE    = 9;
   localparam int NUM_SLOTS   = 9;
   localparam int DIMS        = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic CMD_WRAP = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   typedef enum logic [1:0] {
      SHAPE_INF   = 2'd0,
      SHAPE_ORTHO = 2'd1,
      SHAPE_TRI   = 2'd2
   } shape_type;

   // Classified command travelling from the front to the back.
   typedef struct packed {
      logic       load;
      logic       inv;
      logic [3:0] slot;
   } ctl_type;

endpackage

// ===== hdl/ppw_front.sv =====
// Front end: accepts request words, classifies them and drops out-of-range loads.
module ppw_front #(
   parameter int POS_WIDTH  = 32,
   parameter int COEF_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic [4:0]                            req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]          req_coef_value,
   input  logic signed [POS_WIDTH-1:0]           req_pos_x,
   input  logic signed [POS_WIDTH-1:0]           req_pos_y,
   input  logic signed [POS_WIDTH-1:0]           req_pos_z,
   output logic                                  q_valid,
   input  logic                                  q_ready,
   output ppw_pkg::ctl_type                      q_ctl,
   output logic [COEF_WIDTH+3*POS_WIDTH-1:0]     q_data
);
   import ppw_pkg::*;

   localparam int DW = COEF_WIDTH + 3 * POS_WIDTH;

   logic    v_ff, v_in;
   ctl_type ctl_ff, ctl_in;
   logic [DW-1:0] data_ff;
   logic    take, is_load, drop, is_inv;

   assign req_ready = !v_ff || q_ready;
   assign take      = req_valid && req_ready;
   assign is_load   = (req_cmd == CMD_LOAD);
   assign is_inv    = (req_coef_index >= 5'(INV_BASE));
   // drop loads aimed past the last coefficient slot
   assign drop      = is_load && (req_coef_index >= 5'(NUM_COEF));

   always_comb begin
      v_in = v_ff;
      if (v_ff && q_ready) begin
         v_in = 1'b0;
      end
      if (take) begin
         v_in = !drop;
      end
      ctl_in.load = is_load;
      ctl_in.inv  = is_inv;
      ctl_in.slot = is_inv ? 4'(req_coef_index - 5'(INV_BASE)) : req_coef_index[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (take) begin
         ctl_ff  <= ctl_in;
         data_ff <= {req_coef_value, req_pos_z, req_pos_y, req_pos_x};
      end
   end

   assign q_valid = v_ff;
   assign q_ctl   = ctl_ff;
   assign q_data  = data_ff;

endmodule

// ===== hdl/ppw_queue.sv =====
// Short first-in first-out queue between the front and back ends.
module ppw_queue #(
   parameter int DATA_W = 128,
   parameter int DEPTH  = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  ppw_pkg::ctl_type   push_ctl,
   input  logic [DATA_W-1:0]  push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output ppw_pkg::ctl_type   pop_ctl,
   output logic [DATA_W-1:0]  pop_data
);
   import ppw_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ctl_type           ctl_ff  [DEPTH];
   logic [DATA_W-1:0] data_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push_fire, pop_fire;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_ctl    = ctl_ff[rd_ff];
   assign pop_data   = data_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push_fire) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ff + 1'b1);
      end
      if (pop_fire) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ff + 1'b1);
      end
      if (push_fire && !pop_fire) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (!push_fire && pop_fire) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push_fire) begin
         ctl_ff[wr_ff]  <= push_ctl;
         data_ff[wr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push_fire && !pop_fire |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      !push_fire && pop_fire |=> count_ff == CW'($past(count_ff) - 1'b1))
      else $error("queue count did not drop on pop");

endmodule

// ===== hdl/ppw_back.sv =====
// Back end: coefficient store and the staged wrap pipeline with its output register.
module ppw_back #(
   parameter int POS_WIDTH  = 32,
   parameter int COEF_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ppw_pkg::shape_type                    shape,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  ppw_pkg::ctl_type                      in_ctl,
   input  logic [COEF_WIDTH+3*POS_WIDTH-1:0]     in_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [POS_WIDTH-1:0]           rsp_wrapped_x,
   output logic signed [POS_WIDTH-1:0]           rsp_wrapped_y,
   output logic signed [POS_WIDTH-1:0]           rsp_wrapped_z
);
   import ppw_pkg::*;

   localparam int P  = POS_WIDTH;
   localparam int C  = COEF_WIDTH;
   localparam int MW = P + C;                                    // inverse x position
   localparam int FW = P + C + 2;                                // sum of three
   localparam int NW = (P + C - 44 > 2) ? P + C - 44 : 2;        // image count
   localparam int FX = ((FW > PROD_FRAC + 1) ? FW : PROD_FRAC + 1) + 1;
   localparam int QW = C + NW;                                   // matrix x count
   localparam int RW = ((P > QW) ? P : QW) + 3;

   // coefficient store, no reset: the user keeps it read only after written; the block does not enforce it
   logic signed [C-1:0] inv_ff [NUM_SLOTS];
   logic signed [C-1:0] mat_ff [NUM_SLOTS];

   logic signed [P-1:0] pos_in [DIMS];
   logic signed [C-1:0] val_in;
   logic advance, issue;

   // stage 1: products inverse x position
   logic                v1_ff, v1_in, ldm1_ff;
   logic [3:0]          slot1_ff;
   logic signed [C-1:0] val1_ff;
   logic signed [P-1:0] pos1_ff [DIMS];
   logic signed [MW-1:0] prod1_ff [NUM_SLOTS];
   logic signed [MW-1:0] prod1_in [NUM_SLOTS];
   // stage 2: fractional coordinates
   logic                v2_ff, ldm2_ff;
   logic [3:0]          slot2_ff;
   logic signed [C-1:0] val2_ff;
   logic signed [P-1:0] pos2_ff [DIMS];
   logic signed [FW-1:0] f2_ff [DIMS];
   logic signed [FW-1:0] f2_in [DIMS];
   // stage 3: rounded image counts
   logic                v3_ff, ldm3_ff;
   logic [3:0]          slot3_ff;
   logic signed [C-1:0] val3_ff;
   logic signed [P-1:0] pos3_ff [DIMS];
   logic signed [NW-1:0] n3_ff [DIMS];
   logic signed [NW-1:0] n3_in [DIMS];
   // stage 4: products matrix x count
   logic                v4_ff, v4_in;
   logic signed [P-1:0] pos4_ff [DIMS];
   logic signed [QW-1:0] q4_ff [NUM_SLOTS];
   logic signed [QW-1:0] q4_in [NUM_SLOTS];
   // output register
   logic                out_v_ff;
   logic signed [P-1:0] out_ff [DIMS];
   logic signed [P-1:0] out_in [DIMS];

   assign advance  = !out_v_ff || rsp_ready;
   assign in_ready = advance;
   assign issue    = in_valid && advance;
   assign val_in   = in_data[DIMS*P +: C];
   assign v1_in    = issue && !(in_ctl.load && in_ctl.inv);
   assign v4_in    = v3_ff && !ldm3_ff;

   always_comb begin
      logic signed [C-1:0]  coef;
      logic signed [FX-1:0] fx, mag;
      logic [NW-2:0]        nmag;
      logic signed [RW-1:0] r;
      for (int i = 0; i < DIMS; i++) begin
         pos_in[i] = in_data[i*P +: P];
      end
      // orthorhombic cells use only the diagonal
      for (int j = 0; j < DIMS; j++) begin
         for (int i = 0; i < DIMS; i++) begin
            coef = (shape == SHAPE_ORTHO && i != j) ? '0 : inv_ff[j*DIMS+i];
            prod1_in[j*DIMS+i] = coef * pos_in[i];
         end
      end
      for (int j = 0; j < DIMS; j++) begin
         f2_in[j] = FW'(prod1_ff[j*DIMS]) + FW'(prod1_ff[j*DIMS+1])
                  + FW'(prod1_ff[j*DIMS+2]);
      end
      // round half away from zero on the magnitude
      for (int j = 0; j < DIMS; j++) begin
         fx   = FX'(f2_ff[j]);
         mag  = f2_ff[j][FW-1] ? -fx : fx;
         mag  = mag + (FX'(1) <<< (PROD_FRAC - 1));
         nmag = mag[PROD_FRAC +: NW-1];
         n3_in[j] = f2_ff[j][FW-1] ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});
      end
      for (int i = 0; i < DIMS; i++) begin
         for (int j = 0; j < DIMS; j++) begin
            coef = (shape == SHAPE_ORTHO && i != j) ? '0 : mat_ff[i*DIMS+j];
            q4_in[i*DIMS+j] = coef * n3_ff[j];
         end
      end
      for (int i = 0; i < DIMS; i++) begin
         r = RW'(pos4_ff[i]) - RW'(q4_ff[i*DIMS]) - RW'(q4_ff[i*DIMS+1])
           - RW'(q4_ff[i*DIMS+2]);
         // saturate when the top bits disagree with the sign
         if (r[RW-1:P-1] == '0 || r[RW-1:P-1] == '1) begin
            out_in[i] = r[P-1:0];
         end else begin
            out_in[i] = r[RW-1] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
         end
         unique case (shape)
            SHAPE_ORTHO, SHAPE_TRI: ;
            default: out_in[i] = pos4_ff[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         v1_ff    <= v1_in;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v4_in;
         out_v_ff <= v4_ff;
      end
      if (issue && in_ctl.load && in_ctl.inv) begin
         inv_ff[in_ctl.slot] <= val_in;
      end
      // matrix loads land where wraps read the matrix, keeping order
      if (advance && v3_ff && ldm3_ff) begin
         mat_ff[slot3_ff] <= val3_ff;
      end
      if (advance) begin
         ldm1_ff  <= in_ctl.load;
         slot1_ff <= in_ctl.slot;
         val1_ff  <= val_in;
         ldm2_ff  <= ldm1_ff;
         slot2_ff <= slot1_ff;
         val2_ff  <= val1_ff;
         ldm3_ff  <= ldm2_ff;
         slot3_ff <= slot2_ff;
         val3_ff  <= val2_ff;
         pos1_ff  <= pos_in;
         pos2_ff  <= pos1_ff;
         pos3_ff  <= pos2_ff;
         pos4_ff  <= pos3_ff;
         prod1_ff <= prod1_in;
         f2_ff    <= f2_in;
         n3_ff    <= n3_in;
         q4_ff    <= q4_in;
         out_ff   <= out_in;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_wrapped_x = out_ff[0];
   assign rsp_wrapped_y = out_ff[1];
   assign rsp_wrapped_z = out_ff[2];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff}))
      else $error("pipeline moved while stalled");

   a_wrap_to_out: assert property (@(posedge clock) disable iff (reset)
      v4_ff && advance |=> out_v_ff)
      else $error("wrap lost before the output register");

   a_mat_write: assert property (@(posedge clock) disable iff (reset)
      v3_ff && ldm3_ff && advance |=> mat_ff[$past(slot3_ff)] == $past(val3_ff))
      else $error("matrix load not stored");

endmodule

// ===== hdl/periodic_position_wrap.sv =====
// Top level of the periodic position wrap: shape register, front, queue and back.
//
//   channel  ports                                   handshake
//   req      req_cmd, req_coef_index, req_coef_value,  req_valid / req_ready
//            req_pos_x, req_pos_y, req_pos_z
//   rsp      rsp_wrapped_x, rsp_wrapped_y, rsp_wrapped_z  rsp_valid / rsp_ready
//   csr      csr_cell_shape                          csr_valid / csr_ready
//
// One word per cycle is taken and one wrap result per cycle is given while rsp_ready is high;
// a wrap's word passes the front register, the queue, the back stages and the output register
// before its result is presented.
// Reset clears the valid bits and the shape (pass through); the coefficient store holds
// no reset value. A stalled result freezes the back end; the queue and front fill behind it.
module periodic_position_wrap #(
   parameter int POS_WIDTH  = 32,
   parameter int COEF_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [4:0]                   req_coef_index,
   input  logic signed [COEF_WIDTH-1:0] req_coef_value,
   input  logic signed [POS_WIDTH-1:0]  req_pos_x,
   input  logic signed [POS_WIDTH-1:0]  req_pos_y,
   input  logic signed [POS_WIDTH-1:0]  req_pos_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [POS_WIDTH-1:0]  rsp_wrapped_x,
   output logic signed [POS_WIDTH-1:0]  rsp_wrapped_y,
   output logic signed [POS_WIDTH-1:0]  rsp_wrapped_z,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_cell_shape
);
   import ppw_pkg::*;

   localparam int DW = COEF_WIDTH + 3 * POS_WIDTH;

   shape_type     shape_ff;
   logic          fq_valid, fq_ready, qb_valid, qb_ready;
   ctl_type       fq_ctl, qb_ctl;
   logic [DW-1:0] fq_data, qb_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= SHAPE_INF;
      end else if (csr_valid && csr_ready) begin
         shape_ff <= shape_type'(csr_cell_shape);
      end
   end

   ppw_front #(
      .POS_WIDTH  (POS_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .q_valid        (fq_valid),
      .q_ready        (fq_ready),
      .q_ctl          (fq_ctl),
      .q_data         (fq_data)
   );

   ppw_queue #(
      .DATA_W (DW),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_ctl   (fq_ctl),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_ctl    (qb_ctl),
      .pop_data   (qb_data)
   );

   ppw_back #(
      .POS_WIDTH  (POS_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .shape         (shape_ff),
      .in_valid      (qb_valid),
      .in_ready      (qb_ready),
      .in_ctl        (qb_ctl),
      .in_data       (qb_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_wrapped_x (rsp_wrapped_x),
      .rsp_wrapped_y (rsp_wrapped_y),
      .rsp_wrapped_z (rsp_wrapped_z)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for periodic_position_wrap: directed and random words, predicted per word.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ppw_pkg::*;

   localparam logic [1:0]          SHAPE_SPARE     = 2'd3; // unused code, behaves as pass through
   localparam logic [31:0]         POS_MAX32       = 32'h7FFF_FFFF;
   localparam logic [31:0]         POS_MIN32       = 32'h8000_0000;
   localparam logic signed [127:0] POS_MAX         = 128'sh7FFF_FFFF;
   localparam logic signed [127:0] POS_MIN         = -128'sh8000_0000;
   localparam int                  PHASES          = 12;
   localparam int                  ITEMS_PER_PHASE = 150;
   localparam int                  REST_CYCLES     = 16;
   localparam int                  STALL_LIMIT     = 1000;

   typedef struct packed {
      logic        cmd;
      logic [4:0]  idx;
      logic [31:0] val;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } req_word_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } wrapped_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic        req_cmd        = CMD_WRAP;
   logic [4:0]  req_coef_index = '0;
   logic [31:0] req_coef_value = '0;
   logic [31:0] req_pos_x      = '0;
   logic [31:0] req_pos_y      = '0;
   logic [31:0] req_pos_z      = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [31:0] rsp_wrapped_x;
   logic [31:0] rsp_wrapped_y;
   logic [31:0] rsp_wrapped_z;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_cell_shape = SHAPE_INF;

   req_word_type       req_pending [$];
   wrapped_type        wrapped_due [$];
   logic signed [31:0] coef_copy [NUM_COEF];
   logic [1:0]         shape_copy    = SHAPE_INF;
   int                 send_idle_pct = 14;
   int                 recv_idle_pct = 65;
   int                 n_queued      = 0;
   int                 n_taken       = 0;
   int                 n_fail        = 0;
   int                 stall_cycles  = 0;

   periodic_position_wrap u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_wrapped_x  (rsp_wrapped_x),
      .rsp_wrapped_y  (rsp_wrapped_y),
      .rsp_wrapped_z  (rsp_wrapped_z),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_cell_shape (csr_cell_shape)
   );

   always #2 clock = ~clock;

   // Value with PROD_FRAC fraction bits to the nearest integer, halves away from zero.
   function automatic logic signed [127:0] round_half_away(input logic signed [127:0] f);
      logic signed [127:0] mag;
      mag = (f < 0) ? -f : f;
      mag = (mag + (128'sd1 <<< (PROD_FRAC - 1))) >>> PROD_FRAC;
      return (f < 0) ? -mag : mag;
   endfunction

   function automatic logic [31:0] clamp_pos(input logic signed [127:0] v);
      if (v > POS_MAX) return POS_MAX32;
      if (v < POS_MIN) return POS_MIN32;
      return v[31:0];
   endfunction

   task automatic predict_wrap(input logic signed [31:0] px, py, pz);
      logic signed [127:0] p [3];
      logic signed [127:0] n [3];
      logic signed [127:0] acc;
      logic signed [127:0] c;
      logic [31:0]         r [3];
      wrapped_type         w;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      for (int i = 0; i < DIMS; i++) r[i] = p[i][31:0];
      if (shape_copy == SHAPE_ORTHO) begin
         for (int i = 0; i < DIMS; i++) begin
            // a zero inverse entry leaves the axis alone
            if (coef_copy[INV_BASE + 4 * i] != 0) begin
               c   = coef_copy[INV_BASE + 4 * i];
               acc = round_half_away(p[i] * c);
               c   = coef_copy[4 * i];
               r[i] = clamp_pos(p[i] - c * acc);
            end
         end
      end else if (shape_copy == SHAPE_TRI) begin
         for (int j = 0; j < DIMS; j++) begin
            acc = 0;
            for (int i = 0; i < DIMS; i++) begin
               c   = coef_copy[INV_BASE + DIMS * j + i];
               acc = acc + c * p[i];
            end
            n[j] = round_half_away(acc);
         end
         for (int i = 0; i < DIMS; i++) begin
            acc = p[i];
            for (int j = 0; j < DIMS; j++) begin
               c   = coef_copy[DIMS * i + j];
               acc = acc - c * n[j];
            end
            r[i] = clamp_pos(acc);
         end
      end
      w.x = r[0];
      w.y = r[1];
      w.z = r[2];
      wrapped_due.push_back(w);
   endtask

   task automatic push_load(input logic [4:0] idx, input logic [31:0] val);
      req_word_type w;
      w.cmd = CMD_LOAD;
      w.idx = idx;
      w.val = val;
      w.x   = $urandom;
      w.y   = $urandom;
      w.z   = $urandom;
      req_pending.push_back(w);
      n_queued++;
   endtask

   task automatic push_wrap(input logic [31:0] x, y, z);
      req_word_type w;
      w.cmd = CMD_WRAP;
      w.idx = 5'($urandom_range(31));
      w.val = $urandom;
      w.x   = x;
      w.y   = y;
      w.z   = z;
      req_pending.push_back(w);
      n_queued++;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0:       return POS_MAX32;
               1:       return POS_MIN32;
               2:       return 32'd0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1, 2:    return $urandom;
         // spread magnitudes over a few cells either side
         default: return $signed($urandom) >>> $urandom_range(22, 4);
      endcase
   endfunction

   // Wait for every word to be taken and every result to arrive, then let loads drain.
   task automatic drain_and_rest();
      while (n_taken != n_queued || wrapped_due.size() != 0) @(posedge clock);
      repeat (REST_CYCLES) @(posedge clock);
   endtask

   task automatic write_shape(input logic [1:0] shape);
      csr_valid      <= 1'b1;
      csr_cell_shape <= shape;
      do @(posedge clock); while (!csr_ready);
      shape_copy = shape;
      csr_valid <= 1'b0;
   endtask

   // Driver: predict each accepted word, then offer the next one or idle.
   always @(posedge clock) begin
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_LOAD) begin
               if (req_coef_index < NUM_COEF) coef_copy[req_coef_index] = req_coef_value;
            end else begin
               predict_wrap(req_pos_x, req_pos_y, req_pos_z);
            end
            n_taken++;
         end
         if (!req_valid || req_ready) begin
            if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               w = req_pending.pop_front();
               req_valid      <= 1'b1;
               req_cmd        <= w.cmd;
               req_coef_index <= w.idx;
               req_coef_value <= w.val;
               req_pos_x      <= w.x;
               req_pos_y      <= w.y;
               req_pos_z      <= w.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      wrapped_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (wrapped_due.size() == 0) begin
               $error("result with none expected: %0d %0d %0d", $signed(rsp_wrapped_x),
                      $signed(rsp_wrapped_y), $signed(rsp_wrapped_z));
               n_fail++;
            end else begin
               e = wrapped_due.pop_front();
               if (rsp_wrapped_x !== e.x) begin
                  $error("wrapped_x: expected %0d, got %0d", $signed(e.x),
                         $signed(rsp_wrapped_x));
                  n_fail++;
               end
               if (rsp_wrapped_y !== e.y) begin
                  $error("wrapped_y: expected %0d, got %0d", $signed(e.y),
                         $signed(rsp_wrapped_y));
                  n_fail++;
               end
               if (rsp_wrapped_z !== e.z) begin
                  $error("wrapped_z: expected %0d, got %0d", $signed(e.z),
                         $signed(rsp_wrapped_z));
                  n_fail++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int         cell_words [NUM_COEF];
      logic [1:0] shape;
      int         roll;
      real        lx, ly, lz, off_yx, off_zx, off_zy;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every slot first: a cube of side 8, extremes off the diagonal.
      push_load(0, 32'h0008_0000);  push_load(1, POS_MAX32);
      push_load(2, POS_MIN32);      push_load(3, 32'h0001_0000);
      push_load(4, 32'h0008_0000);  push_load(5, 32'd0);
      push_load(6, 32'hFFFF_0000);  push_load(7, 32'h0002_0000);
      push_load(8, 32'h0008_0000);  push_load(9, 32'h0800_0000);
      push_load(10, 32'h0400_0000); push_load(11, 32'd0);
      push_load(12, 32'hFE00_0000); push_load(13, 32'h0800_0000);
      push_load(14, 32'd0);         push_load(15, 32'd0);
      push_load(16, 32'd0);         push_load(17, 32'd0);
      // out-of-range slots are dropped
      push_load(18, POS_MAX32);
      push_load(31, POS_MIN32);
      push_wrap(POS_MAX32, POS_MIN32, 32'd0);
      push_wrap(32'hFFFF_FFFF, 32'd1, 32'h5A5A_5A5A);
      drain_and_rest();
      // exact halves round away from zero; z has a zero inverse entry
      write_shape(SHAPE_ORTHO);
      push_wrap(32'h0004_0000, 32'hFFFC_0000, 32'h0064_0000);
      push_wrap(POS_MAX32, POS_MIN32, POS_MAX32);
      drain_and_rest();
      // zero inverse row on z, saturation through the extreme matrix entries
      write_shape(SHAPE_TRI);
      push_wrap(32'h0004_0000, 32'hFFFC_0000, 32'h0003_0000);
      push_wrap(POS_MIN32, POS_MAX32, POS_MIN32);
      drain_and_rest();
      write_shape(SHAPE_SPARE);
      push_wrap(32'h007B_8000, 32'hFFF8_C000, POS_MAX32);

      for (int k = 0; k < PHASES; k++) begin
         drain_and_rest();
         if (k < 4) begin
            send_idle_pct = 14;
            recv_idle_pct = 65;
         end else if (k < 8) begin
            send_idle_pct = 65;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (k)
            3:       shape = SHAPE_INF;
            7:       shape = SHAPE_SPARE;
            default: shape = (k % 2 == 0) ? SHAPE_ORTHO : SHAPE_TRI;
         endcase
         write_shape(shape);

         // Load a fresh lower-triangular cell and its inverse most of the time.
         if ((shape == SHAPE_ORTHO || shape == SHAPE_TRI) && $urandom_range(2) != 0) begin
            lx = 2.0 + $urandom_range(198000) / 1000.0;
            ly = 2.0 + $urandom_range(198000) / 1000.0;
            lz = 2.0 + $urandom_range(198000) / 1000.0;
            off_yx = 0.0;
            off_zx = 0.0;
            off_zy = 0.0;
            if (shape == SHAPE_TRI) begin
               off_yx = ($urandom_range(2000) / 1000.0 - 1.0) * 0.5 * ly;
               off_zx = ($urandom_range(2000) / 1000.0 - 1.0) * 0.5 * lz;
               off_zy = ($urandom_range(2000) / 1000.0 - 1.0) * 0.5 * lz;
            end
            foreach (cell_words[i]) cell_words[i] = 0;
            cell_words[0]  = $rtoi(lx * 65536.0);
            cell_words[3]  = $rtoi(off_yx * 65536.0);
            cell_words[4]  = $rtoi(ly * 65536.0);
            cell_words[6]  = $rtoi(off_zx * 65536.0);
            cell_words[7]  = $rtoi(off_zy * 65536.0);
            cell_words[8]  = $rtoi(lz * 65536.0);
            cell_words[9]  = $rtoi(1073741824.0 / lx);
            cell_words[12] = $rtoi(-off_yx / (lx * ly) * 1073741824.0);
            cell_words[13] = $rtoi(1073741824.0 / ly);
            cell_words[15] = $rtoi((off_yx * off_zy - off_zx * ly) / (lx * ly * lz)
                                   * 1073741824.0);
            cell_words[16] = $rtoi(-off_zy / (ly * lz) * 1073741824.0);
            cell_words[17] = $rtoi(1073741824.0 / lz);
            for (int i = 0; i < NUM_COEF; i++) push_load(5'(i), cell_words[i]);
         end

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
               // corrupt one slot, now and then with a zero
               push_load(5'($urandom_range(NUM_COEF - 1)), (roll < 2) ? 32'd0 : $urandom);
            end else if (roll < 8) begin
               push_load(5'($urandom_range(31)), $urandom);
            end else begin
               push_wrap(rand_coord(), rand_coord(), rand_coord());
            end
         end
      end

      drain_and_rest();
      if (n_fail == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
